[sv/brf_pkg.sv]
// shared types and constants of the byte ring fifo
// beat layouts for the channels plus command/status between controller and datapath
// no dependencies
package brf_pkg;

  localparam int unsigned SIZE_W = 11;
  localparam int unsigned DONE_W = 7;

  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_GET   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_SKIP  = 3'd3,
    OP_CLEAR = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [7:0]        data_in;
    logic              block_start;
    logic [SIZE_W-1:0] length;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]        data_out;
    logic              data_valid;
    logic              last;
    logic              status;
    logic [DONE_W-1:0] bytes_done;
    logic [SIZE_W-1:0] used_space;
    logic [SIZE_W-1:0] free_space;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic              accept;
    logic              byte_emit;
    logic              byte_last;
    logic [DONE_W-1:0] byte_cnt;
    logic              burst_get;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [DONE_W-1:0] burst_n;
    logic              burst_get;
  } sts_t;

endpackage

[sv/brf_chan_if.sv]
// valid/ready channel carrying one payload beat
// payload type is set per instance, usually from brf_pkg
interface brf_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/brf_ctrl.sv]
// controller of the byte ring fifo: input handshake, burst sequencing, output valid
// depends on brf_pkg
module brf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  brf_pkg::sts_t sts_i,
  output brf_pkg::cmd_t cmd_o
);
  import brf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  state_e            state_q;
  logic              out_valid_q;
  logic [DONE_W-1:0] n_q;
  logic [DONE_W-1:0] idx_q;
  logic              get_q;

  logic              slot_free;
  logic              accept;
  logic              emit;
  logic [DONE_W-1:0] cnt_nx;
  logic              burst_start;

  // output register is free when empty or its beat is taken now
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && slot_free;
  assign accept      = in_valid_i && in_ready_o;
  assign emit        = (state_q == ST_BURST) && slot_free;
  assign cnt_nx      = idx_q + DONE_W'(1);
  assign burst_start = accept && (sts_i.burst_n != '0);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.accept    = accept;
    cmd_o.byte_emit = emit;
    cmd_o.byte_last = (cnt_nx == n_q);
    cmd_o.byte_cnt  = cnt_nx;
    cmd_o.burst_get = get_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      get_q       <= 1'b0;
    end else begin
      if ((accept && !burst_start) || emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (burst_start) begin
            state_q <= ST_BURST;
            n_q     <= sts_i.burst_n;
            idx_q   <= '0;
            get_q   <= sts_i.burst_get;
          end
        end
        ST_BURST: begin
          if (emit) begin
            idx_q <= cnt_nx;
            if (cnt_nx == n_q) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/brf_dp.sv]
// datapath of the byte ring fifo: byte store, pointers, occupancy, block state, result register
// depends on brf_pkg; driven by brf_ctrl through cmd_t
module brf_dp #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  brf_pkg::cmd_t               cmd_i,
  output brf_pkg::sts_t               sts_o,
  input  brf_pkg::in_beat_t           in_beat_i,
  input  logic                        cfg_we_i,
  input  logic [brf_pkg::SIZE_W-1:0]  cfg_data_i,
  output brf_pkg::out_beat_t          out_beat_o
);
  import brf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  localparam logic [SIZE_W-1:0] RST_SIZE = SIZE_W'((DEPTH < 1024) ? DEPTH : 1024);

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata_q;

  logic [SIZE_W-1:0] size_q, size_d;
  logic [SIZE_W-1:0] used_q, used_d;
  logic [SIZE_W-1:0] free_q, free_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [AW-1:0]     rp_q, rp_d;
  logic [AW-1:0]     walk_q, walk_d;
  logic              blk_act_q, blk_act_d;
  logic [SIZE_W-1:0] blk_rem_q, blk_rem_d;

  logic              o_dv_q, o_dv_d;
  logic              o_last_q, o_last_d;
  logic              o_st_q, o_st_d;
  logic [DONE_W-1:0] o_done_q, o_done_d;
  logic [SIZE_W-1:0] o_used_q, o_free_q;

  logic [SIZE_W-1:0] clamp;
  logic [SIZE_W-1:0] n_sel;
  logic [DONE_W-1:0] burst_n;
  logic              is_burst_op;
  logic [CW-1:0]     skip_t;
  logic              put_st;
  logic              wr_en;
  logic              ld;

  function automatic logic [AW-1:0] ptr_step(input logic [AW-1:0] p,
                                             input logic [SIZE_W-1:0] s);
    logic [CW-1:0] nx;
    nx = CW'(p) + CW'(1);
    if (nx >= CW'(s)) return '0;
    return AW'(nx);
  endfunction

  // size register value: zero acts as one, capped at the store depth
  always_comb begin
    if (cfg_data_i == '0) begin
      clamp = SIZE_W'(1);
    end else if (32'(cfg_data_i) > 32'(DEPTH)) begin
      clamp = SIZE_W'(DEPTH);
    end else begin
      clamp = cfg_data_i;
    end
  end

  // byte count of a get or peek
  always_comb begin
    n_sel = in_beat_i.length;
    if (n_sel > used_q) n_sel = used_q;
    if (n_sel > SIZE_W'(MAX_BURST)) n_sel = SIZE_W'(MAX_BURST);
  end

  assign is_burst_op     = (in_beat_i.opcode == OP_GET) || (in_beat_i.opcode == OP_PEEK);
  assign burst_n         = is_burst_op ? DONE_W'(n_sel) : '0;
  assign sts_o.burst_n   = burst_n;
  assign sts_o.burst_get = (in_beat_i.opcode == OP_GET);

  always_comb begin
    skip_t = CW'(rp_q) + CW'(in_beat_i.length);
    if (skip_t >= CW'(size_q)) skip_t = skip_t - CW'(size_q);
  end

  always_comb begin
    size_d    = size_q;
    used_d    = used_q;
    free_d    = free_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    walk_d    = walk_q;
    blk_act_d = blk_act_q;
    blk_rem_d = blk_rem_q;
    put_st    = 1'b0;
    wr_en     = 1'b0;
    ld        = 1'b0;
    o_dv_d    = 1'b0;
    o_last_d  = 1'b1;
    o_st_d    = 1'b0;
    o_done_d  = '0;

    if (cfg_we_i) begin
      size_d    = clamp;
      used_d    = '0;
      free_d    = clamp;
      wp_d      = '0;
      rp_d      = '0;
      blk_act_d = 1'b0;
      blk_rem_d = '0;
    end else if (cmd_i.accept) begin
      ld = 1'b1;
      case (in_beat_i.opcode)
        OP_PUT: begin
          if (in_beat_i.block_start) begin
            blk_act_d = 1'b0;
            blk_rem_d = '0;
            if (in_beat_i.length > free_q) begin
              put_st = 1'b1;
            end else if (in_beat_i.length != '0) begin
              blk_act_d = 1'b1;
              blk_rem_d = in_beat_i.length;
            end
          end else if (!blk_act_q) begin
            put_st = 1'b1;
          end
          if (blk_act_d && (blk_rem_d != '0)) begin
            wr_en     = 1'b1;
            wp_d      = ptr_step(wp_q, size_q);
            used_d    = used_q + SIZE_W'(1);
            free_d    = free_q - SIZE_W'(1);
            blk_rem_d = blk_rem_d - SIZE_W'(1);
            if (blk_rem_d == '0) blk_act_d = 1'b0;
          end
          o_st_d = put_st;
        end
        OP_GET, OP_PEEK: begin
          if (burst_n != '0) begin
            // bytes follow one per cycle while the output register is free, nothing shown now
            ld     = 1'b0;
            walk_d = rp_q;
            if (in_beat_i.opcode == OP_GET) begin
              used_d = used_q - SIZE_W'(burst_n);
              free_d = free_q + SIZE_W'(burst_n);
            end
          end
        end
        OP_SKIP: begin
          if (in_beat_i.length > used_q) begin
            o_st_d = 1'b1;
          end else begin
            rp_d   = AW'(skip_t);
            used_d = used_q - in_beat_i.length;
            free_d = free_q + in_beat_i.length;
          end
        end
        OP_CLEAR: begin
          used_d    = '0;
          free_d    = size_q;
          wp_d      = '0;
          rp_d      = '0;
          blk_act_d = 1'b0;
          blk_rem_d = '0;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.byte_emit) begin
      ld       = 1'b1;
      o_dv_d   = 1'b1;
      o_last_d = cmd_i.byte_last;
      o_done_d = cmd_i.byte_cnt;
      walk_d   = ptr_step(walk_q, size_q);
      // get moves the read pointer once the burst is done
      if (cmd_i.byte_last && cmd_i.burst_get) begin
        rp_d = ptr_step(walk_q, size_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= RST_SIZE;
      used_q    <= '0;
      free_q    <= RST_SIZE;
      wp_q      <= '0;
      rp_q      <= '0;
      blk_act_q <= 1'b0;
      blk_rem_q <= '0;
    end else begin
      size_q    <= size_d;
      used_q    <= used_d;
      free_q    <= free_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      blk_act_q <= blk_act_d;
      blk_rem_q <= blk_rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q <= walk_d;
    if (wr_en) begin
      mem[wp_q] <= in_beat_i.data_in;
    end
    if (cmd_i.byte_emit) begin
      rdata_q <= mem[walk_q];
    end
    if (ld) begin
      o_dv_q   <= o_dv_d;
      o_last_q <= o_last_d;
      o_st_q   <= o_st_d;
      o_done_q <= o_done_d;
      o_used_q <= used_d;
      o_free_q <= free_d;
    end
  end

  always_comb begin
    out_beat_o.data_out   = o_dv_q ? rdata_q : 8'd0;
    out_beat_o.data_valid = o_dv_q;
    out_beat_o.last       = o_last_q;
    out_beat_o.status     = o_st_q;
    out_beat_o.bytes_done = o_done_q;
    out_beat_o.used_space = o_used_q;
    out_beat_o.free_space = o_free_q;
  end

endmodule

[sv/byte_ring_fifo_with_peek_skip.sv]
// top level of the byte ring fifo with peek and skip
// depends on brf_pkg, brf_chan_if, brf_ctrl, brf_dp
//
// Usage: commands arrive as beats on in_i (put byte, get, peek, skip, clear) and every
// command yields one or more result beats on out_i; each result carries the used and
// free byte counts after the command. cfg_i writes the buffer size, which also empties
// the fifo; write it only while no command is in flight. cfg_i is always ready.
// Put, skip, clear and unknown codes: one result beat, registered, in the cycle after
// the command beat is taken; such a command can be taken every cycle unless results stall.
// Get and peek returning n bytes (n at most MAX_BURST): the command beat sets up the
// burst with no result, then one result beat per cycle while the receiver keeps up, from
// the store's single registered read port; with nothing to return, a single result.
// Reset leaves the fifo empty with a size of 1024 slots (capped at DEPTH); store
// contents are not cleared and need no clearing pass.
// A stalled receiver holds the pending result in the output register; bursts pause
// and no new command is taken until the register frees up.
module byte_ring_fifo_with_peek_skip #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  brf_chan_if.sink   in_i,
  brf_chan_if.source out_o,
  brf_chan_if.sink   cfg_i
);
  import brf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  brf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brf_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_beat_i  (in_i.payload),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.payload),
    .out_beat_o (out_o.payload)
  );

endmodule

[sv/brf_chk.sv]
// port-level checks for the byte ring fifo, bound to the top level
// depends on brf_pkg
module brf_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input brf_pkg::out_beat_t out_beat_i
);
  import brf_pkg::*;

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_beat_i))
    else $error("result changed while stalled");

  // no command taken while a burst still has bytes to go
  a_no_cmd_mid_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_beat_i.data_valid && !out_beat_i.last |-> !in_ready_i)
    else $error("command taken in the middle of a burst");

  // results without a byte carry no byte and no count
  a_nodata_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_beat_i.data_valid |->
      out_beat_i.data_out == 8'd0 && out_beat_i.bytes_done == '0 && out_beat_i.last)
    else $error("non-data result malformed");

  // data beats count from one and never report a refusal
  a_data_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_beat_i.data_valid |->
      out_beat_i.bytes_done != '0 && !out_beat_i.status)
    else $error("data result malformed");

endmodule

bind byte_ring_fifo_with_peek_skip brf_chk u_brf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.payload)
);

[verif/brf_result_checker.sv]
`timescale 1ns / 1ps
// result checker for the byte ring fifo: watches command, result and size-write beats
// keeps its own copy of the fifo state and compares every result beat; uses brf_pkg
module brf_result_checker #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  brf_pkg::in_beat_t          in_beat_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  brf_pkg::out_beat_t         out_beat_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [brf_pkg::SIZE_W-1:0] cfg_data_i,
  output int                         errors_o,
  output int                         pending_o
);
  import brf_pkg::*;

  logic [7:0]        store_mem [DEPTH];
  int unsigned       wr_ptr;
  int unsigned       rd_ptr;
  bit                wrap_par;
  bit                blk_open;
  int unsigned       blk_left;
  logic [SIZE_W-1:0] size_reg;
  out_beat_t         result_q [$];
  out_beat_t         exp_r;
  int                fail_cnt = 0;

  assign errors_o = fail_cnt;

  // size register values outside 1..DEPTH are clamped
  function automatic int unsigned eff_size();
    if (size_reg == '0) return 1;
    if (size_reg > DEPTH) return DEPTH;
    return size_reg;
  endfunction

  function automatic int unsigned used_bytes();
    return wrap_par ? eff_size() + wr_ptr - rd_ptr : wr_ptr - rd_ptr;
  endfunction

  function automatic int unsigned next_ptr(input int unsigned p, output bit wrapped);
    wrapped = (p + 1 >= eff_size());
    return wrapped ? 0 : p + 1;
  endfunction

  function automatic string beat_str(input out_beat_t b);
    return $sformatf("data=%02h dv=%0b last=%0b st=%0b done=%0d used=%0d free=%0d",
                     b.data_out, b.data_valid, b.last, b.status, b.bytes_done,
                     b.used_space, b.free_space);
  endfunction

  task automatic empty_fifo();
    wr_ptr   = 0;
    rd_ptr   = 0;
    wrap_par = 1'b0;
    blk_open = 1'b0;
    blk_left = 0;
  endtask

  // occupancy fields reflect the state after the whole command
  task automatic queue_result(input logic [7:0] data, input logic dv, input logic lst,
                              input logic st, input int unsigned done);
    out_beat_t   r;
    int unsigned u;
    u            = used_bytes();
    r.data_out   = data;
    r.data_valid = dv;
    r.last       = lst;
    r.status     = st;
    r.bytes_done = DONE_W'(done);
    r.used_space = SIZE_W'(u);
    r.free_space = SIZE_W'(eff_size() - u);
    result_q.push_back(r);
  endtask

  task automatic apply_cmd(input in_beat_t c);
    logic [7:0]  burst [MAX_BURST];
    int unsigned n;
    int unsigned p;
    int unsigned k;
    bit          wr;
    bit          st;
    st = 1'b0;
    case (c.opcode)
      OP_PUT: begin
        if (c.block_start) begin
          blk_open = 1'b0;
          blk_left = 0;
          if (c.length > eff_size() - used_bytes()) begin
            st = 1'b1;
          end else if (c.length != 0) begin
            blk_open = 1'b1;
            blk_left = c.length;
          end
        end else if (!blk_open) begin
          st = 1'b1;
        end
        if (blk_open && blk_left != 0) begin
          store_mem[wr_ptr] = c.data_in;
          wr_ptr = next_ptr(wr_ptr, wr);
          if (wr) wrap_par = ~wrap_par;
          blk_left--;
          if (blk_left == 0) blk_open = 1'b0;
        end
        queue_result(8'h00, 1'b0, 1'b1, st, 0);
      end
      OP_GET, OP_PEEK: begin
        n = c.length;
        if (n > used_bytes()) n = used_bytes();
        if (n > MAX_BURST) n = MAX_BURST;
        p = rd_ptr;
        for (k = 0; k < n; k++) begin
          burst[k] = store_mem[p];
          p = next_ptr(p, wr);
          // only a get moves the read side, so only a get flips parity
          if (wr && c.opcode == OP_GET) wrap_par = ~wrap_par;
        end
        if (c.opcode == OP_GET) rd_ptr = p;
        if (n == 0) queue_result(8'h00, 1'b0, 1'b1, 1'b0, 0);
        for (k = 0; k < n; k++) begin
          queue_result(burst[k], 1'b1, k + 1 == n, 1'b0, k + 1);
        end
      end
      OP_SKIP: begin
        if (c.length > used_bytes()) begin
          st = 1'b1;
        end else begin
          p = rd_ptr + c.length;
          if (p >= eff_size()) begin
            wrap_par = ~wrap_par;
            p -= eff_size();
          end
          rd_ptr = p;
        end
        queue_result(8'h00, 1'b0, 1'b1, st, 0);
      end
      OP_CLEAR: begin
        empty_fifo();
        queue_result(8'h00, 1'b0, 1'b1, 1'b0, 0);
      end
      default: begin
        queue_result(8'h00, 1'b0, 1'b1, 1'b0, 0);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q.delete();
      size_reg = SIZE_W'(1024);
      empty_fifo();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result beat with nothing expected, got %s", $time,
                   beat_str(out_beat_i));
        end else begin
          exp_r = result_q.pop_front();
          if (out_beat_i.data_out   !== exp_r.data_out   ||
              out_beat_i.data_valid !== exp_r.data_valid ||
              out_beat_i.last       !== exp_r.last       ||
              out_beat_i.status     !== exp_r.status     ||
              out_beat_i.bytes_done !== exp_r.bytes_done ||
              out_beat_i.used_space !== exp_r.used_space ||
              out_beat_i.free_space !== exp_r.free_space) begin
            fail_cnt++;
            $display("%0t: result mismatch, expected %s, got %s", $time,
                     beat_str(exp_r), beat_str(out_beat_i));
          end
        end
      end
      // a size write empties the fifo and drops any open block
      if (cfg_valid_i && cfg_ready_i) begin
        size_reg = cfg_data_i;
        empty_fifo();
      end
      if (in_valid_i && in_ready_i) apply_cmd(in_beat_i);
    end
    pending_o = result_q.size();
  end

endmodule

[verif/tb_byte_ring_fifo_with_peek_skip.sv]
`timescale 1ns / 1ps
// testbench top for byte_ring_fifo_with_peek_skip: clock, reset, command and size stimulus
// depends on brf_pkg, brf_chan_if, the block itself and brf_result_checker
module tb_byte_ring_fifo_with_peek_skip;
  import brf_pkg::*;

  // codes the block does not define
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  logic clk;
  logic rst_n;
  int   fail_cnt;
  int   pending;
  int   snd_idle = 36;
  int   rcv_idle = 82;
  int   cmd_cnt  = 0;
  int   cur_eff  = 1024;

  brf_chan_if #(.T(in_beat_t))          cmd_if ();
  brf_chan_if #(.T(out_beat_t))         res_if ();
  brf_chan_if #(.T(logic [SIZE_W-1:0])) cfg_if ();

  byte_ring_fifo_with_peek_skip u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  brf_result_checker u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (cmd_if.valid),
    .in_ready_i  (cmd_if.ready),
    .in_beat_i   (cmd_if.payload),
    .out_valid_i (res_if.valid),
    .out_ready_i (res_if.ready),
    .out_beat_i  (res_if.payload),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_data_i  (cfg_if.payload),
    .errors_o    (fail_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  initial begin
    #4_000_000;
    $display("tb_byte_ring_fifo_with_peek_skip failed");
    $finish;
  end

  // entered and left at a falling edge
  task automatic send_cmd(input logic [2:0] op, input logic [7:0] din, input logic bst,
                          input int unsigned len);
    in_beat_t b;
    b.opcode      = op;
    b.data_in     = din;
    b.block_start = bst;
    b.length      = len[SIZE_W-1:0];
    while ($urandom_range(0, 99) < snd_idle) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.payload = b;
    cmd_if.valid   = 1'b1;
    do @(posedge clk); while (!cmd_if.ready);
    @(negedge clk);
    cmd_cnt++;
  endtask

  task automatic put_block(input int unsigned len, input int unsigned nbeats);
    int unsigned k;
    send_cmd(OP_PUT, 8'($urandom_range(0, 255)), 1'b1, len);
    for (k = 1; k < nbeats; k++)
      send_cmd(OP_PUT, 8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 2047));
  endtask

  task automatic drain();
    cmd_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    drain();
    cfg_if.payload = v;
    cfg_if.valid   = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
    cur_eff = (v == 0) ? 1 : ((v > 1024) ? 1024 : v);
  endtask

  task automatic random_phase(input int n);
    int          start;
    int unsigned kind;
    int unsigned len;
    int unsigned base;
    int unsigned cap;
    int unsigned r;
    int unsigned nb;
    start = cmd_cnt;
    cap   = (cur_eff <= 16) ? cur_eff + 1 : 72;
    while (cmd_cnt - start < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, cap);
        base = (len == 0) ? 1 : len;
        // oversized blocks get a short tail only
        if (base > cap + 1) base = 3;
        r = $urandom_range(0, 9);
        if (r == 0) nb = $urandom_range(1, base);
        else if (r == 1) nb = base + $urandom_range(1, 3);
        else nb = base;
        put_block(len, nb);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, cap);
        if (kind < 65)
          send_cmd(OP_GET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), len);
        else if (kind < 78)
          send_cmd(OP_PEEK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), len);
        else if (kind < 92)
          send_cmd(OP_SKIP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), len);
        else if (kind < 96)
          send_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), len);
        else
          send_cmd(3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), len);
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    random_phase(15);

    // directed pass on a four-slot fifo
    write_size(SIZE_W'(4));
    send_cmd(OP_GET, 8'h00, 1'b0, 5);          // get from empty
    send_cmd(OP_PEEK, 8'hff, 1'b1, 0);
    send_cmd(OP_PUT, 8'h01, 1'b1, 5);          // block larger than free space
    send_cmd(OP_PUT, 8'h02, 1'b0, 0);          // tail of refused block
    send_cmd(OP_PUT, 8'h03, 1'b1, 0);          // empty block
    send_cmd(OP_PUT, 8'h04, 1'b0, 0);          // stray byte
    send_cmd(OP_PUT, 8'h00, 1'b1, 4);          // fill to full, write side wraps
    send_cmd(OP_PUT, 8'hff, 1'b0, 2047);
    send_cmd(OP_PUT, 8'ha5, 1'b0, 0);
    send_cmd(OP_PUT, 8'h5a, 1'b0, 0);
    send_cmd(OP_PUT, 8'h77, 1'b1, 1);          // no room left
    send_cmd(OP_PEEK, 8'h00, 1'b0, 2047);
    send_cmd(OP_GET, 8'h00, 1'b0, 2);
    send_cmd(OP_SKIP, 8'h00, 1'b0, 3);         // more than held
    send_cmd(OP_PUT, 8'h11, 1'b1, 2);
    send_cmd(OP_PUT, 8'h22, 1'b0, 0);
    send_cmd(OP_SKIP, 8'h00, 1'b0, 3);         // read side wraps on skip
    send_cmd(OP_GET, 8'h00, 1'b0, 64);
    send_cmd(OP_PUT, 8'h33, 1'b1, 3);
    send_cmd(OP_PUT, 8'h44, 1'b0, 0);
    send_cmd(OP_CLEAR, 8'hff, 1'b1, 2047);     // clear drops the open block
    send_cmd(OP_PUT, 8'h55, 1'b0, 0);
    send_cmd(OP_RSVD_LO, 8'hff, 1'b1, 2047);
    send_cmd(OP_RSVD_HI, 8'h00, 1'b0, 0);
    send_cmd(OP_SKIP, 8'h00, 1'b0, 0);

    random_phase(30);
    write_size(SIZE_W'(0));
    random_phase(20);

    snd_idle = 82;
    rcv_idle = 36;
    write_size(SIZE_W'(2047));
    random_phase(35);
    write_size(SIZE_W'(2));
    random_phase(20);

    snd_idle = 0;
    rcv_idle = 0;
    write_size(SIZE_W'(1024));
    random_phase(25);
    write_size(SIZE_W'(7));
    random_phase(25);

    drain();
    repeat (8) @(negedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb_byte_ring_fifo_with_peek_skip passed");
    end else begin
      $display("tb_byte_ring_fifo_with_peek_skip failed");
    end
    $finish;
  end

endmodule
